// ===== hdl/fcrc_pkg.sv =====
// Shared constants and the byte-wide CRC-32 update function for the frame checker.
package fcrc_pkg;

    localparam int unsigned DataWidth = 8;
    localparam int unsigned CrcWidth  = 32;

    localparam logic [CrcWidth-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef logic [DataWidth-1:0] data_t;
    typedef logic [CrcWidth-1:0]  crc_t;

    // Fold one byte into a reflected CRC-32, LSB first.
    function automatic crc_t crc_byte(input crc_t crc, input data_t data);
        crc_t c;
        c = crc ^ {{(CrcWidth-DataWidth){1'b0}}, data};
        for (int k = 0; k < DataWidth; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/fcrc_if.sv =====
// Valid/ready channel interfaces for frame bytes and per-frame results.
interface fcrc_byte_if
    import fcrc_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t data_byte;
    logic  frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface fcrc_res_if
    import fcrc_pkg::*;
();
    logic valid;
    logic ready;
    crc_t frame_crc;
    logic is_reference;
    logic matches_reference;
    logic run_stable;

    modport source (output valid, output frame_crc, output is_reference,
                    output matches_reference, output run_stable, input ready);
    modport sink   (input valid, input frame_crc, input is_reference,
                    input matches_reference, input run_stable, output ready);
endinterface

// ===== hdl/fcrc_in_reg.sv =====
// Input register stage: captures one byte item and holds it until the CRC stage takes it.
module fcrc_in_reg
    import fcrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fcrc_byte_if.sink    snk,
    fcrc_byte_if.source  src
);

    logic  valid_reg;
    data_t data_reg;
    logic  last_reg;

    assign snk.ready      = !valid_reg || src.ready;
    assign src.valid      = valid_reg;
    assign src.data_byte  = data_reg;
    assign src.frame_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (snk.valid && snk.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (src.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload: load on every accepted item
    always_ff @(posedge clk)
    begin
        if (snk.valid && snk.ready)
        begin
            data_reg <= snk.data_byte;
            last_reg <= snk.frame_last;
        end
    end

endmodule

// ===== hdl/fcrc_check.sv =====
// CRC fold, reference compare and result register for the frame checker.
module fcrc_check
    import fcrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fcrc_byte_if.sink    snk,
    fcrc_res_if.source   res
);

    crc_t running_crc_reg;
    crc_t reference_crc_reg;
    logic have_reference_reg;
    logic stable_reg;

    logic out_valid_reg;
    crc_t out_crc_reg;
    logic out_is_ref_reg;
    logic out_match_reg;
    logic out_stable_reg;

    crc_t crc_next;
    crc_t done;
    logic match;
    logic fire;
    logic fire_last;

    assign crc_next = crc_byte(running_crc_reg, snk.data_byte);
    assign done     = crc_next ^ CRC_ONES;
    assign match    = !have_reference_reg || (done == reference_crc_reg);

    // Bytes inside a frame never wait; only a frame end needs a free result slot
    assign snk.ready = !snk.frame_last || !out_valid_reg || res.ready;
    assign fire      = snk.valid && snk.ready;
    assign fire_last = fire && snk.frame_last;

    assign res.valid             = out_valid_reg;
    assign res.frame_crc         = out_crc_reg;
    assign res.is_reference      = out_is_ref_reg;
    assign res.matches_reference = out_match_reg;
    assign res.run_stable        = out_stable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg    <= CRC_ONES;
            reference_crc_reg  <= '0;
            have_reference_reg <= 1'b0;
            stable_reg         <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                running_crc_reg <= snk.frame_last ? CRC_ONES : crc_next;
            end
            if (fire_last)
            begin
                if (!have_reference_reg)
                begin
                    reference_crc_reg  <= done;
                    have_reference_reg <= 1'b1;
                end
                else if (!match)
                begin
                    stable_reg <= 1'b0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_last)
        begin
            out_crc_reg    <= done;
            out_is_ref_reg <= !have_reference_reg;
            out_match_reg  <= match;
            out_stable_reg <= stable_reg && match;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_is_ref_reg |-> out_match_reg)
        else $error("reference frame reported as mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(have_reference_reg))
        else $error("stored reference lost without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(stable_reg))
        else $error("stable flag set again without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire_last |=> running_crc_reg == CRC_ONES)
        else $error("running CRC not restarted after frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stable_reg) |-> $past(have_reference_reg))
        else $error("stable flag cleared by the reference frame");

endmodule

// ===== hdl/frame_crc32_stability_check.sv =====
// Top level of the frame CRC-32 stability checker.
// Takes one frame byte per cycle on byte_in (frame_last marks the final byte) and keeps a
// running reflected CRC-32 (poly 0xEDB88320, init and final XOR all ones). Each frame end
// yields one item on crc_out with the frame's CRC; the first frame after reset becomes the
// reference, later frames are compared against it, and run_stable drops for good on the first
// mismatch until reset. Throughput is one byte per cycle except while a frame's last byte
// waits: an input register feeds a combinational byte-wide XOR network and the result register.
// Bytes inside a frame keep flowing while a result waits; a frame's last byte waits only while
// the previous result is still unclaimed.
module frame_crc32_stability_check
    import fcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fcrc_byte_if.sink   byte_in,
    fcrc_res_if.source  crc_out
);

    fcrc_byte_if stage_ch ();

    fcrc_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .snk   (byte_in),
        .src   (stage_ch.source)
    );

    fcrc_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .snk   (stage_ch.sink),
        .res   (crc_out)
    );

endmodule
